// ===== src/bfld_pkg.sv =====
// ----------------------------------------------------------------------------
// bfld_pkg
// Shared types, sizes and helpers for the byte FIFO with line detection.
// ----------------------------------------------------------------------------
package bfld_pkg;

    localparam int DEPTH = 256;
    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int SAT_W = (PTR_W > 8) ? PTR_W : 8;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] EMPTY_BYTE = 8'hFF;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_STATUS = 2'd2,
        OP_SPARE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DROPPED = 2'd1,
        ST_REFUSED = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    function automatic t_ptr next_ptr(input t_ptr p);
        next_ptr = (p == t_ptr'(DEPTH - 1)) ? '0 : t_ptr'(p + t_ptr'(1));
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        is_eol = (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_QMARK);
    endfunction

endpackage

// ===== src/byte_fifo_with_line_detect_unit.sv =====
// ----------------------------------------------------------------------------
// byte_fifo_with_line_detect_unit
// Byte ring buffer held in RAM with drop counting and end-of-line tracking.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   data_in[7:0], block[8], zero pad to 16      op[1:0]
// m_axis   out  read_data[7:0], fill_count[15:8],           status[1:0]
//               has_char[16], has_line[17],
//               dropped_total[49:18], zero pad to 56
//
// Push, status, spare and pop-on-empty register the result from idle; a
// pop of a held byte first waits in S_READ for the RAM's registered data.
// One transaction is in flight at a time; the output register frees the
// input side as soon as the result is taken or in the same cycle.
// Reset clears pointers, fill, end-of-line and drop counters; ring RAM
// contents are not cleared. A stalled m_axis holds the result and s_axis.
// ----------------------------------------------------------------------------
module byte_fifo_with_line_detect_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_in[7:0], block[8]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // read_data, fill_count, has_char, has_line, dropped_total
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state            r_state, n_state;
    bfld_pkg::t_ptr    r_wp, n_wp;
    bfld_pkg::t_ptr    r_rp, n_rp;
    bfld_pkg::t_ptr    r_fill, n_fill;
    bfld_pkg::t_ptr    r_eol, n_eol;
    logic [31:0]       r_drop, n_drop;
    logic              r_m_valid, n_m_valid;
    bfld_pkg::t_status r_status, n_status;
    logic [7:0]        r_read_data, n_read_data;
    logic [7:0]        r_fill_out, n_fill_out;
    logic              r_has_char, n_has_char;
    logic              r_has_line, n_has_line;
    logic [31:0]       r_drop_out, n_drop_out;

    logic                 accept;
    bfld_pkg::t_op        in_op;
    logic [7:0]           in_data;
    logic                 in_block;
    logic                 full;
    logic                 empty;
    logic                 ram_we;
    logic                 ram_re;
    logic [7:0]           ram_rdata;
    logic                 produce;
    logic [bfld_pkg::SAT_W-1:0] fill_ext;

    assign in_op    = bfld_pkg::t_op'(s_axis_tuser);
    assign in_data  = s_axis_tdata[7:0];
    assign in_block = s_axis_tdata[8];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full  = (r_fill == bfld_pkg::t_ptr'(bfld_pkg::DEPTH - 1));
    assign empty = (r_fill == '0);

    assign ram_we = accept && (in_op == bfld_pkg::OP_PUSH) && !full;
    assign ram_re = accept && (in_op == bfld_pkg::OP_POP) && !empty;

    bfld_ram #(
        .P_WIDTH (8),
        .P_DEPTH (bfld_pkg::DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (in_data),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_fill      = r_fill;
        n_eol       = r_eol;
        n_drop      = r_drop;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_status    = bfld_pkg::ST_OK;
        n_read_data = '0;
        produce     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        bfld_pkg::OP_PUSH: begin
                            produce = 1'b1;
                            if (full) begin
                                if (in_block) begin
                                    n_status = bfld_pkg::ST_REFUSED;
                                end else begin
                                    n_status = bfld_pkg::ST_DROPPED;
                                    n_drop   = r_drop + 32'd1;
                                end
                            end else begin
                                n_wp   = bfld_pkg::next_ptr(r_wp);
                                n_fill = r_fill + bfld_pkg::t_ptr'(1);
                                if (bfld_pkg::is_eol(in_data)) begin
                                    n_eol = r_eol + bfld_pkg::t_ptr'(1);
                                end
                            end
                        end
                        bfld_pkg::OP_POP: begin
                            if (empty) begin
                                produce     = 1'b1;
                                n_status    = bfld_pkg::ST_EMPTY;
                                n_read_data = bfld_pkg::EMPTY_BYTE;
                            end else begin
                                n_rp    = bfld_pkg::next_ptr(r_rp);
                                n_fill  = r_fill - bfld_pkg::t_ptr'(1);
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                produce     = 1'b1;
                n_read_data = ram_rdata;
                n_state     = S_IDLE;
                if (bfld_pkg::is_eol(ram_rdata) && (r_eol != '0)) begin
                    n_eol = r_eol - bfld_pkg::t_ptr'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        fill_ext   = bfld_pkg::SAT_W'(n_fill);
        n_fill_out = (fill_ext > bfld_pkg::SAT_W'(255)) ? 8'hFF : fill_ext[7:0];
        n_has_char = (n_fill != '0);
        n_has_line = (n_eol != '0);
        n_drop_out = n_drop;
        if (produce) begin
            n_m_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_fill    <= '0;
            r_eol     <= '0;
            r_drop    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_fill    <= n_fill;
            r_eol     <= n_eol;
            r_drop    <= n_drop;
            r_m_valid <= n_m_valid;
        end
        if (produce) begin
            r_status    <= n_status;
            r_read_data <= n_read_data;
            r_fill_out  <= n_fill_out;
            r_has_char  <= n_has_char;
            r_has_line  <= n_has_line;
            r_drop_out  <= n_drop_out;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {6'd0, r_drop_out, r_has_line, r_has_char, r_fill_out, r_read_data};

`ifndef SYNTH
    logic [bfld_pkg::PTR_W:0] ptr_span;
    assign ptr_span = (r_wp >= r_rp)
                    ? ({1'b0, r_wp} - {1'b0, r_rp})
                    : ({1'b0, r_wp} + (bfld_pkg::PTR_W+1)'(bfld_pkg::DEPTH) - {1'b0, r_rp});

    a_fill_matches_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ptr_span == {1'b0, r_fill})
        else $error("fill count disagrees with pointers");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= bfld_pkg::t_ptr'(bfld_pkg::DEPTH - 1))
        else $error("fill count beyond usable depth");

    a_eol_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_eol <= r_fill))
        else $error("end-of-line count exceeds fill");

    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_state == S_READ) && !r_m_valid)
        else $error("pop did not enter read with free output");
`endif

endmodule

// ===== src/bfld_ram.sv =====
// ----------------------------------------------------------------------------
// bfld_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfld_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((P_DEPTH > 2) ? $clog2(P_DEPTH) : 1)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]                            i_wdata,
    input  logic                                          i_re,
    input  logic [((P_DEPTH > 2) ? $clog2(P_DEPTH) : 1)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]                            o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
